// ----- rtl/core/dlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dlsp_pkg
// Shared types, constants and microcode table of the duty lookup speed
// controller.
// ----------------------------------------------------------------------------
package dlsp_pkg;

   localparam int unsigned WarmupTicksDefault = 7;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] duty_command;
      logic signed [15:0] measured_velocity;
   } dlsp_req_type;

   typedef struct packed {
      logic signed [15:0] torque_command;
      logic               torque_limited;
   } dlsp_rsp_type;

   localparam logic OP_SET_DUTY = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   typedef enum logic [2:0] {
      CSR_SPEED_GAIN,
      CSR_TORQUE_LIMIT,
      CSR_INVERT_DIRECTION,
      CSR_SPEED_TENTH,
      CSR_SPEED_TWO_TENTHS,
      CSR_SPEED_THREE_TENTHS
   } dlsp_csr_type;

   localparam logic [11:0]        GAIN_RESET        = 12'd896;
   localparam logic [14:0]        LIMIT_RESET       = 15'd4608;
   localparam logic signed [15:0] SPEED_TENTH_RESET = 16'sd1280;
   localparam logic signed [15:0] SPEED_TWO_RESET   = 16'sd2816;
   localparam logic signed [15:0] SPEED_THREE_RESET = 16'sd4352;

   localparam logic signed [15:0] DUTY_ONE     = 16'sd16384;
   localparam logic signed [15:0] DUTY_NEG_ONE = -16'sd16384;
   localparam logic [14:0]        BP1          = 15'd1638;
   localparam logic [14:0]        BP2          = 15'd3277;
   localparam logic [14:0]        BP3          = 15'd4915;
   // ceil(2^38 / spacing), exact for dividends below 2^27
   localparam logic [27:0]        RECIP_NARROW = 28'd167813131;
   localparam logic [27:0]        RECIP_WIDE   = 28'd167710743;
   localparam logic [26:0]        DEN_HALF     = 27'd819;
   localparam logic [30:0]        TQ_HALF      = 31'd128;

   typedef enum logic [2:0] {
      UOP_SELECT,
      UOP_MUL,
      UOP_DIV_INIT,
      UOP_RECIP,
      UOP_TARGET,
      UOP_FINISH
   } dlsp_uop_type;

   typedef enum logic [1:0] {
      BR_SEQ,
      BR_SKIP,
      BR_END
   } dlsp_branch_type;

   typedef logic [2:0] dlsp_upc_type;

   typedef struct packed {
      dlsp_uop_type    uop;
      dlsp_branch_type branch;
      dlsp_upc_type    target;
   } dlsp_uword_type;

   localparam dlsp_upc_type UPC_START  = 3'd0;
   localparam dlsp_upc_type UPC_TARGET = 3'd4;

   function automatic dlsp_uword_type dlsp_ucode(input dlsp_upc_type upc);
      dlsp_uword_type w;
      case (upc)
         3'd0:    w = '{UOP_SELECT,   BR_SKIP, UPC_TARGET};
         3'd1:    w = '{UOP_MUL,      BR_SEQ,  UPC_START};
         3'd2:    w = '{UOP_DIV_INIT, BR_SEQ,  UPC_START};
         3'd3:    w = '{UOP_RECIP,    BR_SEQ,  UPC_START};
         3'd4:    w = '{UOP_TARGET,   BR_SEQ,  UPC_START};
         3'd5:    w = '{UOP_MUL,      BR_SEQ,  UPC_START};
         3'd6:    w = '{UOP_FINISH,   BR_END,  UPC_START};
         default: w = '{UOP_FINISH,   BR_END,  UPC_START};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/duty_lookup_speed_p_controller.sv -----
// ----------------------------------------------------------------------------
// duty_lookup_speed_p_controller
// Duty-to-speed lookup followed by a proportional speed loop with clamp.
// ----------------------------------------------------------------------------
// A set-duty request and a warm-up tick are absorbed in the cycle they are
// accepted. A control tick after warm-up runs a microprogram: segment
// select, slope multiply, rounding, reciprocal multiply for the fixed
// breakpoint spacing, error, gain multiply and clamp. A duty at or beyond 0.3
// skips the interpolation. Input stalls while the program runs, and its last
// step holds while an earlier response still waits in the output register;
// a finished response waits there while the next request is taken. Config
// writes are always ready.
module duty_lookup_speed_p_controller
   import dlsp_pkg::*;
#(
   parameter int unsigned WARMUP_TICKS = WarmupTicksDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dlsp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dlsp_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   logic               busy_ff, busy_in;
   dlsp_upc_type       upc_ff, upc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dlsp_rsp_type       rsp_data_ff, rsp_data_in;
   logic [3:0]         warmup_ff, warmup_in;
   logic signed [15:0] duty_ff, duty_in;
   logic [11:0]        gain_ff, gain_in;
   logic [14:0]        limit_ff, limit_in;
   logic               invert_ff, invert_in;
   logic signed [15:0] s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;

   logic signed [15:0] vel_ff, vel_in;
   logic signed [12:0] opa_ff, opa_in;
   logic signed [17:0] opb_ff, opb_in;
   logic signed [30:0] prod_ff, prod_in;
   logic signed [15:0] lo_ff, lo_in;
   logic               neg_ff, neg_in, sat_ff, sat_in, wide_ff, wide_in;
   logic [26:0]        rem_ff, rem_in;
   logic [15:0]        quot_ff, quot_in;
   logic               qneg_ff, qneg_in;

   dlsp_uword_type     uword;
   logic signed [15:0] duty_clamped, duty_abs16, seg_hi, seg_lo;
   logic [14:0]        duty_abs, seg_x0;
   logic               seg_wide, duty_sat;
   logic signed [30:0] mul_out;
   logic [30:0]        prod_mag;
   logic [27:0]        recip;
   logic [54:0]        recip_prod;
   logic signed [16:0] q_signed, seg_sum, target;
   logic signed [15:0] speed;
   logic signed [17:0] err;
   logic [30:0]        tq_sum;
   logic [22:0]        tq_abs;
   logic               tq_limited;
   logic [15:0]        tq_mag;

   assign uword     = dlsp_ucode(upc_ff);
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_data.duty_command > DUTY_ONE) begin
         duty_clamped = DUTY_ONE;
      end else if (req_data.duty_command < DUTY_NEG_ONE) begin
         duty_clamped = DUTY_NEG_ONE;
      end else begin
         duty_clamped = req_data.duty_command;
      end
   end

   assign duty_abs16 = duty_ff[15] ? -duty_ff : duty_ff;
   assign duty_abs   = duty_abs16[14:0];
   assign duty_sat   = duty_abs >= BP3;

   always_comb begin
      if (duty_abs >= BP2) begin
         seg_x0 = BP2; seg_lo = s2_ff; seg_hi = s3_ff; seg_wide = 1'b0;
      end else if (duty_abs >= BP1) begin
         seg_x0 = BP1; seg_lo = s1_ff; seg_hi = s2_ff; seg_wide = 1'b1;
      end else begin
         seg_x0 = '0; seg_lo = '0; seg_hi = s1_ff; seg_wide = 1'b0;
      end
   end

   assign mul_out    = opa_ff * opb_ff;
   assign prod_mag   = prod_ff[30] ? 31'(-prod_ff) : 31'(prod_ff);
   assign recip      = wide_ff ? RECIP_WIDE : RECIP_NARROW;
   assign recip_prod = 55'(rem_ff) * 55'(recip);

   assign q_signed = qneg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   assign seg_sum  = 17'(lo_ff) + q_signed;
   assign speed    = sat_ff ? s3_ff : seg_sum[15:0];
   assign target   = neg_ff ? -17'(speed) : 17'(speed);
   assign err      = 18'(target) - 18'(vel_ff);

   assign tq_sum     = prod_mag + TQ_HALF;
   assign tq_abs     = tq_sum[30:8];
   assign tq_limited = tq_abs > {8'd0, limit_ff};
   assign tq_mag     = tq_limited ? {1'b0, limit_ff} : tq_abs[15:0];

   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      warmup_in    = warmup_ff;
      duty_in      = duty_ff;
      gain_in      = gain_ff;
      limit_in     = limit_ff;
      invert_in    = invert_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      s3_in        = s3_ff;
      vel_in       = vel_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      prod_in      = prod_ff;
      lo_in        = lo_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      wide_in      = wide_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      qneg_in      = qneg_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_SPEED_GAIN:         gain_in   = csr_data[11:0];
            CSR_TORQUE_LIMIT:       limit_in  = csr_data[14:0];
            CSR_INVERT_DIRECTION:   invert_in = csr_data[0];
            CSR_SPEED_TENTH:        s1_in     = csr_data;
            CSR_SPEED_TWO_TENTHS:   s2_in     = csr_data;
            CSR_SPEED_THREE_TENTHS: s3_in     = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_valid && !busy_ff) begin
         if (req_data.operation == OP_SET_DUTY) begin
            duty_in = invert_ff ? -duty_clamped : duty_clamped;
         end else if (warmup_ff < 4'(WARMUP_TICKS)) begin
            warmup_in = warmup_ff + 4'd1;
         end else begin
            busy_in = 1'b1;
            upc_in  = UPC_START;
            vel_in  = req_data.measured_velocity;
         end
      end

      if (busy_ff) begin
         case (uword.uop)
            UOP_SELECT: begin
               neg_in  = duty_ff[15];
               sat_in  = duty_sat;
               wide_in = seg_wide;
               lo_in   = seg_lo;
               opa_in  = $signed({2'b00, 11'(duty_abs - seg_x0)});
               opb_in  = 18'(seg_hi) - 18'(seg_lo);
            end
            UOP_MUL: begin
               prod_in = mul_out;
            end
            UOP_DIV_INIT: begin
               qneg_in = prod_ff[30];
               rem_in  = prod_mag[26:0] + DEN_HALF;
            end
            UOP_RECIP: begin
               quot_in = recip_prod[53:38];
            end
            UOP_TARGET: begin
               opa_in = $signed({1'b0, gain_ff});
               opb_in = err;
            end
            UOP_FINISH: ;
            default: ;
         endcase

         case (uword.branch)
            BR_SEQ: upc_in = upc_ff + 3'd1;
            BR_SKIP: begin
               upc_in = duty_sat ? uword.target : upc_ff + 3'd1;
            end
            BR_END: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  busy_in                    = 1'b0;
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.torque_command = prod_ff[30] ? -tq_mag : tq_mag;
                  rsp_data_in.torque_limited = tq_limited;
               end
            end
            default: upc_in = UPC_START;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= UPC_START;
         rsp_valid_ff <= 1'b0;
         warmup_ff    <= '0;
         duty_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         limit_ff     <= LIMIT_RESET;
         invert_ff    <= 1'b0;
         s1_ff        <= SPEED_TENTH_RESET;
         s2_ff        <= SPEED_TWO_RESET;
         s3_ff        <= SPEED_THREE_RESET;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         warmup_ff    <= warmup_in;
         duty_ff      <= duty_in;
         gain_ff      <= gain_in;
         limit_ff     <= limit_in;
         invert_ff    <= invert_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      vel_ff      <= vel_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      prod_ff     <= prod_in;
      lo_ff       <= lo_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      wide_ff     <= wide_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      qneg_ff     <= qneg_in;
   end

endmodule

// ----- rtl/core/dlsp_checker.sv -----
// ----------------------------------------------------------------------------
// dlsp_props
// Port-level checks of the duty lookup speed controller.
// ----------------------------------------------------------------------------
module dlsp_props
   import dlsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input dlsp_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input dlsp_rsp_type rsp_data
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a new response only ends a busy program
   a_rsp_from_program: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a running program");

   // set-duty requests never occupy the sequencer
   a_set_duty_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_SET_DUTY |=> !req_stall)
      else $error("set-duty request stalled the input");

endmodule

bind duty_lookup_speed_p_controller dlsp_props u_dlsp_props (.*);

// ----- dv/dlsp_checker.sv -----
// ----------------------------------------------------------------------------
// dlsp_checker
// Watches the request, response and register channels of the duty lookup
// speed controller. Keeps its own copy of the registers, the held duty and
// the warm-up count, predicts the torque response of every control tick after
// warm-up and compares each accepted response, field by field, in order.
// ----------------------------------------------------------------------------
module dlsp_checker
   import dlsp_pkg::*;
#(
   parameter int unsigned WARMUP_TICKS = WarmupTicksDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  dlsp_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  dlsp_rsp_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int unsigned  error_count,
   output int unsigned  torque_backlog
);

   logic [11:0]        gain;
   logic [14:0]        limit;
   logic               invert;
   logic signed [15:0] sp_tenth;
   logic signed [15:0] sp_two;
   logic signed [15:0] sp_three;
   int                 duty_held;
   logic [3:0]         ticks_seen;
   dlsp_rsp_type       torque_queue[$];

   task automatic report_mismatch(input string msg);
      $display("%0t dlsp_checker: %s", $time, msg);
      error_count = error_count + 1;
   endtask

   // round to nearest, ties away from zero; den > 0
   function automatic longint round_div(input longint num, input longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint interpolate(input longint mag, input longint x0,
                                          input longint x1, input longint lo,
                                          input longint hi);
      return lo + round_div((mag - x0) * (hi - lo), x1 - x0);
   endfunction

   function automatic longint speed_for_duty(input int duty);
      longint mag;
      longint s;
      mag = (duty < 0) ? -duty : duty;
      if (mag == 0) return 0;
      if (mag >= BP3)
         s = sp_three;
      else if (mag >= BP2)
         s = interpolate(mag, BP2, BP3, sp_two, sp_three);
      else if (mag >= BP1)
         s = interpolate(mag, BP1, BP2, sp_tenth, sp_two);
      else
         s = interpolate(mag, 0, BP1, 0, sp_tenth);
      return (duty < 0) ? -s : s;
   endfunction

   function automatic dlsp_rsp_type torque_for(input logic signed [15:0] velocity);
      longint       err;
      longint       tq;
      longint       lim;
      dlsp_rsp_type r;
      err = speed_for_duty(duty_held) - longint'(velocity);
      tq  = round_div(longint'(gain) * err, 256);
      lim = longint'(limit);
      r.torque_limited = 1'b0;
      if (tq > lim) begin
         tq = lim;
         r.torque_limited = 1'b1;
      end
      if (tq < -lim) begin
         tq = -lim;
         r.torque_limited = 1'b1;
      end
      r.torque_command = tq[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      dlsp_rsp_type want;
      int           duty;
      if (reset) begin
         gain       = GAIN_RESET;
         limit      = LIMIT_RESET;
         invert     = 1'b0;
         sp_tenth   = SPEED_TENTH_RESET;
         sp_two     = SPEED_TWO_RESET;
         sp_three   = SPEED_THREE_RESET;
         duty_held  = 0;
         ticks_seen = '0;
         torque_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPEED_GAIN:         gain     = csr_data[11:0];
               CSR_TORQUE_LIMIT:       limit    = csr_data[14:0];
               CSR_INVERT_DIRECTION:   invert   = csr_data[0];
               CSR_SPEED_TENTH:        sp_tenth = csr_data;
               CSR_SPEED_TWO_TENTHS:   sp_two   = csr_data;
               CSR_SPEED_THREE_TENTHS: sp_three = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (torque_queue.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0b with no tick pending",
                                         rsp_data.torque_command,
                                         rsp_data.torque_limited));
            end else begin
               want = torque_queue.pop_front();
               if (rsp_data.torque_command !== want.torque_command)
                  report_mismatch($sformatf("torque_command got %0d expected %0d",
                                            rsp_data.torque_command,
                                            want.torque_command));
               if (rsp_data.torque_limited !== want.torque_limited)
                  report_mismatch($sformatf("torque_limited got %0b expected %0b",
                                            rsp_data.torque_limited,
                                            want.torque_limited));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.operation == OP_SET_DUTY) begin
               duty = req_data.duty_command;
               if (duty > int'(DUTY_ONE)) duty = DUTY_ONE;
               if (duty < int'(DUTY_NEG_ONE)) duty = DUTY_NEG_ONE;
               duty_held = invert ? -duty : duty;
            end else if (ticks_seen < WARMUP_TICKS) begin
               ticks_seen = ticks_seen + 1'b1;
            end else begin
               torque_queue.push_back(torque_for(req_data.measured_velocity));
            end
         end
      end
      torque_backlog <= torque_queue.size();
   end

endmodule

// ----- dv/tb_duty_lookup_speed_p_controller.sv -----
// ----------------------------------------------------------------------------
// tb_duty_lookup_speed_p_controller
// Drives set-duty and tick requests into the controller under random gaps
// and response back-pressure, including one long receiver hold-off, across
// several register settings. Checking is done by dlsp_checker.
// ----------------------------------------------------------------------------
module tb_duty_lookup_speed_p_controller;
   import dlsp_pkg::*;

   localparam int unsigned SettleCycles  = 40;
   localparam int unsigned QuietLimit    = 3000;
   localparam int unsigned HoldCycles    = 300;
   localparam int unsigned PhaseCount    = 8;
   localparam int unsigned ItemsPerPhase = 141;
   localparam logic [2:0]  CsrUnusedIndex = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   dlsp_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   dlsp_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;
   int unsigned  error_count;
   int unsigned  torque_backlog;
   int unsigned  quiet_cycles = 0;
   bit           hold_requested = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   duty_lookup_speed_p_controller dut (.*);
   dlsp_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("tb_duty_lookup_speed_p_controller: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response back-pressure
   initial begin
      int pick;
      int run;
      @(posedge clock);
      forever begin
         if (hold_requested) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_requested = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_stall <= 1'b0;
               run = $urandom_range(1, 20);
            end else if (pick < 85) begin
               rsp_stall <= 1'b1;
               run = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic dlsp_req_type make_request(input logic op, input int duty,
                                                 input int velocity);
      dlsp_req_type r;
      r.operation         = op;
      r.duty_command      = duty[15:0];
      r.measured_velocity = velocity[15:0];
      return r;
   endfunction

   function automatic int pick_gap(input bit burst);
      int pick;
      pick = $urandom_range(0, 99);
      if (burst || pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic dlsp_req_type random_request();
      int duty;
      int velocity;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         duty = $urandom_range(0, 65535);
      end else if (pick < 6) begin
         case ($urandom_range(0, 4))
            0:       duty = 0;
            1:       duty = int'(BP1);
            2:       duty = int'(BP2);
            3:       duty = int'(BP3);
            default: duty = int'(DUTY_ONE);
         endcase
         duty = duty + $urandom_range(0, 6) - 3;
      end else begin
         duty = $urandom_range(0, 5200);
      end
      if (pick >= 3 && $urandom_range(0, 1)) duty = -duty;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         velocity = $urandom_range(0, 65535);
      else if (pick < 7)
         velocity = $urandom_range(0, 3000) - 1500;
      else
         velocity = $urandom_range(0, 10000) - 5000;
      return make_request(($urandom_range(0, 99) < 40) ? OP_SET_DUTY : OP_TICK,
                          duty, velocity);
   endfunction

   task automatic send_request(input dlsp_req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (torque_backlog != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic program_phase(input int phase);
      case (phase)
         0: ;
         1: begin
            write_register(CSR_SPEED_GAIN, 16'hFFFF);
            write_register(CSR_TORQUE_LIMIT, 16'hFFFF);
            write_register(CSR_INVERT_DIRECTION, 16'hFFFF);
            write_register(CSR_SPEED_TENTH, 16'h7FFF);
            write_register(CSR_SPEED_TWO_TENTHS, 16'h8000);
            write_register(CSR_SPEED_THREE_TENTHS, 16'h7FFF);
            write_register(CsrUnusedIndex, 16'($urandom_range(0, 65535)));
         end
         2: begin
            write_register(CSR_SPEED_GAIN, 16'hF000);
            write_register(CSR_TORQUE_LIMIT, 16'h8000);
            write_register(CSR_INVERT_DIRECTION, 16'hFFFE);
            write_register(CSR_SPEED_TENTH, 16'h8000);
            write_register(CSR_SPEED_TWO_TENTHS, 16'h7FFF);
            write_register(CSR_SPEED_THREE_TENTHS, 16'h8000);
         end
         3: begin
            write_register(CSR_SPEED_GAIN, 16'd256);
            write_register(CSR_TORQUE_LIMIT, 16'h7FFF);
            write_register(CSR_INVERT_DIRECTION, 16'd0);
            write_register(CSR_SPEED_TENTH, -16'sd1280);
            write_register(CSR_SPEED_TWO_TENTHS, -16'sd2816);
            write_register(CSR_SPEED_THREE_TENTHS, -16'sd4352);
         end
         4: begin
            write_register(CSR_SPEED_GAIN, 16'(GAIN_RESET));
            write_register(CSR_TORQUE_LIMIT, 16'(LIMIT_RESET));
            write_register(CSR_INVERT_DIRECTION, 16'd1);
            write_register(CSR_SPEED_TENTH, SPEED_TENTH_RESET);
            write_register(CSR_SPEED_TWO_TENTHS, SPEED_TWO_RESET);
            write_register(CSR_SPEED_THREE_TENTHS, SPEED_THREE_RESET);
         end
         default: begin
            write_register(CSR_SPEED_GAIN, 16'($urandom_range(0, 65535)));
            write_register(CSR_TORQUE_LIMIT, 16'($urandom_range(0, 65535)));
            write_register(CSR_INVERT_DIRECTION, 16'($urandom_range(0, 65535)));
            write_register(CSR_SPEED_TENTH, 16'($urandom_range(0, 65535)));
            write_register(CSR_SPEED_TWO_TENTHS, 16'($urandom_range(0, 65535)));
            write_register(CSR_SPEED_THREE_TENTHS, 16'($urandom_range(0, 65535)));
         end
      endcase
      if (phase != 0) csr_valid <= 1'b0;
   endtask

   initial begin
      dlsp_req_type directed[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // warm-up ticks, one saturating set-duty among them
      directed.push_back(make_request(OP_TICK, 0, 32767));
      directed.push_back(make_request(OP_SET_DUTY, 32767, -32768));
      directed.push_back(make_request(OP_TICK, -32768, -32768));
      directed.push_back(make_request(OP_TICK, 100, 0));
      directed.push_back(make_request(OP_TICK, 0, 1));
      directed.push_back(make_request(OP_TICK, 0, -1));
      directed.push_back(make_request(OP_TICK, 0, 12345));
      directed.push_back(make_request(OP_TICK, 0, -12345));
      // duty map corners, each followed by a tick
      directed.push_back(make_request(OP_SET_DUTY, 0, 0));
      directed.push_back(make_request(OP_TICK, 0, 0));
      directed.push_back(make_request(OP_SET_DUTY, -32768, 0));
      directed.push_back(make_request(OP_TICK, 0, 32767));
      directed.push_back(make_request(OP_SET_DUTY, int'(BP1), 0));
      directed.push_back(make_request(OP_TICK, 0, 0));
      directed.push_back(make_request(OP_SET_DUTY, int'(BP2), 0));
      directed.push_back(make_request(OP_TICK, 0, 1280));
      directed.push_back(make_request(OP_SET_DUTY, int'(BP3) - 1, 0));
      directed.push_back(make_request(OP_TICK, 0, -1));
      directed.push_back(make_request(OP_SET_DUTY, -1, 0));
      directed.push_back(make_request(OP_TICK, 0, 0));
      directed.push_back(make_request(OP_SET_DUTY, int'(DUTY_ONE) + 1, 0));
      directed.push_back(make_request(OP_TICK, 0, -32768));
      directed.push_back(make_request(OP_SET_DUTY, 800, 0));
      directed.push_back(make_request(OP_TICK, 0, 256));
      foreach (directed[i]) send_request(directed[i], pick_gap(1'b0));
      drain();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         program_phase(phase);
         if (phase == 1) hold_requested = 1'b1;
         for (int n = 0; n < ItemsPerPhase; n++)
            send_request(random_request(), pick_gap(phase == 3));
         drain();
      end

      if (error_count == 0)
         $display("tb_duty_lookup_speed_p_controller: done, clean");
      else
         $display("tb_duty_lookup_speed_p_controller: done, errors");
      $finish;
   end

endmodule
